>>> rtl/bcrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcrf_pkg
// Operation codes, special register numbers and masks shared by the
// banked core register file.
// ----------------------------------------------------------------------------
package bcrf_pkg;

  // access kind carried by each transaction
  typedef enum logic [1:0] {
    OP_CORE_READ     = 2'd0,
    OP_CORE_WRITE    = 2'd1,
    OP_SPECIAL_READ  = 2'd2,
    OP_SPECIAL_WRITE = 2'd3
  } op_t;

  // core register numbers with a role of their own
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  // special register numbers
  localparam logic [3:0] SPEC_XPSR      = 4'd0;
  localparam logic [3:0] SPEC_APSR      = 4'd1;
  localparam logic [3:0] SPEC_IPSR      = 4'd2;
  localparam logic [3:0] SPEC_EPSR      = 4'd3;
  localparam logic [3:0] SPEC_PRIMASK   = 4'd4;
  localparam logic [3:0] SPEC_BASEPRI   = 4'd5;
  localparam logic [3:0] SPEC_FAULTMASK = 4'd6;
  localparam logic [3:0] SPEC_CONTROL   = 4'd7;
  localparam logic [3:0] SPEC_MODE      = 4'd8;
  localparam logic [3:0] SPEC_MODE_SEL  = 4'd9;
  localparam logic [3:0] SPEC_UFSR      = 4'd10;

  // address and status masks
  localparam logic [31:0] SP_MASK         = 32'hffff_fffc;
  localparam logic [31:0] PC_MASK         = 32'hffff_fffe;
  localparam logic [31:0] IPSR_FIELD_MASK = 32'h0000_01ff;
  localparam logic [31:0] EPSR_FIELD_MASK = 32'h0700_fc00;
  localparam logic [31:0] APSR_FIELD_DSP  = 32'hf80f_0000;
  localparam logic [31:0] APSR_FIELD_BASE = 32'hf800_0000;
  localparam logic [31:0] LR_RESET        = 32'hffff_ffff;

endpackage
`default_nettype wire

>>> rtl/banked_core_register_file.sv
`default_nettype none
// A transaction is captured in registers when accepted; its result is then
// held in the output register. No new transaction is accepted until the one in
// flight completes. Core memory is read on accept and written on completion.
// Reset: control state and special registers clear at once; core register
// entries read as their reset values until first written (no clearing pass).
// ----------------------------------------------------------------------------
// banked_core_register_file
// Core registers (general, banked stack pointers, link, program counter) in a
// synchronous memory with per-entry valid bits; special registers in flops.
// ----------------------------------------------------------------------------
module banked_core_register_file #(
  parameter int NUM_GPRS = 13
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // request channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [3:0]  reg_index,
  input  wire logic [3:0]  special_index,
  input  wire logic [31:0] write_value,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      read_data,
  output logic             pc_redirect,
  output logic [31:0]      redirect_target
);

  localparam int DEPTH = NUM_GPRS + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SLOT_MSP = AW'(NUM_GPRS);
  localparam logic [AW-1:0] SLOT_PSP = AW'(NUM_GPRS + 1);
  localparam logic [AW-1:0] SLOT_LR  = AW'(NUM_GPRS + 2);
  localparam logic [AW-1:0] SLOT_PC  = AW'(NUM_GPRS + 3);

  // configuration
  logic dsp_present;

  // special registers
  logic [31:0] app_status;
  logic [31:0] intr_status;
  logic [31:0] exec_status;
  logic        prio_mask;
  logic [7:0]  base_prio;
  logic        fault_mask;
  logic        unpriv_bit;
  logic        stack_select;
  logic        handler_mode;
  logic [31:0] usage_fault_status;

  // core register memory and entry valid bits
  logic [31:0]      core_mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;
  logic [31:0]      mem_rdata;
  logic             mem_hit;

  // transaction in flight
  logic            busy;
  bcrf_pkg::op_t   op_q;
  logic [3:0]      reg_q;
  logic [3:0]      spec_q;
  logic [31:0]     value_q;
  logic [AW-1:0]   addr_q;

  logic            item_accept;
  logic            done;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     core_value;
  logic [31:0]     core_rdata;
  logic [31:0]     spec_rdata;
  logic [31:0]     apsr_view;
  logic [31:0]     wr_value;
  logic            core_wr;
  logic            spec_wr;
  logic [31:0]     read_data_next;
  logic            pc_redirect_next;
  logic [31:0]     redirect_target_next;

  assign cfg_ready   = 1'b1;
  assign item_stall  = busy;
  assign item_accept = item_valid && !item_stall;
  assign done        = busy && (!result_valid || !result_stall);
  assign apsr_view   = dsp_present ? bcrf_pkg::APSR_FIELD_DSP
                                   : bcrf_pkg::APSR_FIELD_BASE;
  assign core_wr     = done && (op_q == bcrf_pkg::OP_CORE_WRITE);
  assign spec_wr     = done && (op_q == bcrf_pkg::OP_SPECIAL_WRITE);

  // memory slot for a core register number, stack pointer banked
  always_comb begin
    if (32'(reg_index) < NUM_GPRS) begin
      rd_addr = AW'(reg_index);
    end else if (reg_index == bcrf_pkg::REG_SP) begin
      rd_addr = stack_select ? SLOT_PSP : SLOT_MSP;
    end else if (reg_index == bcrf_pkg::REG_LR) begin
      rd_addr = SLOT_LR;
    end else begin
      rd_addr = SLOT_PC;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dsp_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dsp_present <= cfg_data;
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (item_accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      op_q    <= bcrf_pkg::op_t'(operation);
      reg_q   <= reg_index;
      spec_q  <= special_index;
      value_q <= write_value;
      addr_q  <= rd_addr;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (item_accept) begin
      mem_rdata <= core_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_hit <= 1'b0;
    end else if (item_accept) begin
      mem_hit <= entry_valid[rd_addr];
    end
  end

  // value written back for a core write
  always_comb begin
    if (addr_q == SLOT_MSP || addr_q == SLOT_PSP) begin
      wr_value = value_q & bcrf_pkg::SP_MASK;
    end else if (addr_q == SLOT_PC) begin
      wr_value = value_q & bcrf_pkg::PC_MASK;
    end else begin
      wr_value = value_q;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (core_wr) begin
      core_mem[addr_q] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (core_wr) begin
      entry_valid[addr_q] <= 1'b1;
    end
  end

  // core read data, unwritten entries show their reset value
  always_comb begin
    if (mem_hit) begin
      core_value = mem_rdata;
    end else if (addr_q == SLOT_LR) begin
      core_value = bcrf_pkg::LR_RESET;
    end else begin
      core_value = '0;
    end
    if (reg_q == bcrf_pkg::REG_SP) begin
      core_rdata = core_value & bcrf_pkg::SP_MASK;
    end else if (reg_q == bcrf_pkg::REG_PC) begin
      core_rdata = core_value & bcrf_pkg::PC_MASK;
    end else begin
      core_rdata = core_value;
    end
  end

  // special register read decode
  always_comb begin
    unique case (spec_q)
      bcrf_pkg::SPEC_XPSR: begin
        spec_rdata = (intr_status & bcrf_pkg::IPSR_FIELD_MASK)
                   | (exec_status & bcrf_pkg::EPSR_FIELD_MASK)
                   | (app_status & apsr_view);
      end
      bcrf_pkg::SPEC_APSR:      spec_rdata = app_status;
      bcrf_pkg::SPEC_IPSR:      spec_rdata = intr_status;
      bcrf_pkg::SPEC_EPSR:      spec_rdata = exec_status;
      bcrf_pkg::SPEC_PRIMASK:   spec_rdata = {31'b0, prio_mask};
      bcrf_pkg::SPEC_BASEPRI:   spec_rdata = {24'b0, base_prio};
      bcrf_pkg::SPEC_FAULTMASK: spec_rdata = {31'b0, fault_mask};
      bcrf_pkg::SPEC_CONTROL:   spec_rdata = {30'b0, stack_select, unpriv_bit};
      bcrf_pkg::SPEC_MODE:      spec_rdata = {31'b0, handler_mode};
      bcrf_pkg::SPEC_MODE_SEL:  spec_rdata = {30'b0, handler_mode, stack_select};
      bcrf_pkg::SPEC_UFSR:      spec_rdata = usage_fault_status;
      default:                  spec_rdata = '0;
    endcase
  end

  // special register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      app_status         <= '0;
      intr_status        <= '0;
      exec_status        <= '0;
      prio_mask          <= 1'b0;
      base_prio          <= '0;
      fault_mask         <= 1'b0;
      unpriv_bit         <= 1'b0;
      stack_select       <= 1'b0;
      handler_mode       <= 1'b0;
      usage_fault_status <= '0;
    end else if (spec_wr) begin
      unique case (spec_q)
        bcrf_pkg::SPEC_XPSR: begin
          intr_status <= (intr_status & ~bcrf_pkg::IPSR_FIELD_MASK)
                       | (value_q & bcrf_pkg::IPSR_FIELD_MASK);
          exec_status <= (exec_status & ~bcrf_pkg::EPSR_FIELD_MASK)
                       | (value_q & bcrf_pkg::EPSR_FIELD_MASK);
          app_status  <= (app_status & ~apsr_view) | (value_q & apsr_view);
        end
        bcrf_pkg::SPEC_APSR:      app_status <= value_q;
        bcrf_pkg::SPEC_IPSR:      intr_status <= value_q;
        bcrf_pkg::SPEC_EPSR:      exec_status <= value_q;
        bcrf_pkg::SPEC_PRIMASK:   prio_mask <= value_q[0];
        bcrf_pkg::SPEC_BASEPRI:   base_prio <= value_q[7:0];
        bcrf_pkg::SPEC_FAULTMASK: fault_mask <= value_q[0];
        bcrf_pkg::SPEC_CONTROL: begin
          unpriv_bit   <= value_q[0];
          stack_select <= value_q[1];
        end
        bcrf_pkg::SPEC_MODE:      handler_mode <= value_q[0];
        bcrf_pkg::SPEC_MODE_SEL: begin
          stack_select <= value_q[0];
          handler_mode <= value_q[1];
        end
        bcrf_pkg::SPEC_UFSR:      usage_fault_status <= value_q;
        default: begin
        end
      endcase
    end
  end

  // result formation
  always_comb begin
    read_data_next       = '0;
    pc_redirect_next     = 1'b0;
    redirect_target_next = '0;
    case (op_q)
      bcrf_pkg::OP_CORE_READ:    read_data_next = core_rdata;
      bcrf_pkg::OP_SPECIAL_READ: read_data_next = spec_rdata;
      bcrf_pkg::OP_CORE_WRITE: begin
        if (reg_q == bcrf_pkg::REG_PC) begin
          pc_redirect_next     = 1'b1;
          redirect_target_next = value_q & bcrf_pkg::PC_MASK;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_data       <= read_data_next;
      pc_redirect     <= pc_redirect_next;
      redirect_target <= redirect_target_next;
    end
  end

`ifndef SYNTHESIS
  // one transaction in flight at a time
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    item_accept |=> !item_accept)
    else $error("request accepted while one is in flight");

  // a new result only follows a transaction in flight
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy))
    else $error("result without a transaction in flight");

  // redirect target carries a halfword-aligned address
  a_redirect_aligned: assert property (@(posedge clk) disable iff (rst)
    (result_valid && pc_redirect) |-> (redirect_target[0] == 1'b0))
    else $error("redirect target bit 0 set");

  // no target without a redirect
  a_redirect_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !pc_redirect) |-> (redirect_target == '0))
    else $error("redirect target set without redirect");
`endif

endmodule
`default_nettype wire
